// ===== rtl/php_pkg.sv =====
// Shared types, codes and helpers for the periodic halo padding block.
// Used by every module under rtl; depends on nothing else.
package php_pkg;

  // Size limits of the source matrix and of the halo.
  localparam int MAX_DIM     = 4096;
  localparam int MAX_HALO    = 255;
  localparam int QUEUE_DEPTH = 4;

  // Field widths.
  localparam int CNT_W    = 12;
  localparam int DIM_W    = 13;
  localparam int HALO_W   = 8;
  localparam int ADDR_W   = 24;
  localparam int VALUE_W  = 64;
  localparam int REGION_W = 4;
  localparam int NUM_RGN  = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER_WIDTH   = 3'd0,
    CFG_INNER_HEIGHT  = 3'd1,
    CFG_PADDED_WIDTH  = 3'd2,
    CFG_PADDED_HEIGHT = 3'd3,
    CFG_HALO_COLS     = 3'd4,
    CFG_HALO_ROWS     = 3'd5,
    CFG_WRAP_ROWS     = 3'd6,
    CFG_WRAP_COLS     = 3'd7
  } cfg_reg_t;

  // Destination regions, in the order their writes are issued.
  typedef enum logic [REGION_W-1:0] {
    RGN_INTERIOR   = 4'd0,
    RGN_DOWN       = 4'd1,
    RGN_DOWN_RIGHT = 4'd2,
    RGN_DOWN_LEFT  = 4'd3,
    RGN_UP         = 4'd4,
    RGN_UP_RIGHT   = 4'd5,
    RGN_UP_LEFT    = 4'd6,
    RGN_RIGHT      = 4'd7,
    RGN_LEFT       = 4'd8
  } region_t;

  // Which precomputed row and column a region uses.
  typedef enum logic [1:0] {
    ROW_MID  = 2'd0,
    ROW_DOWN = 2'd1,
    ROW_UP   = 2'd2
  } row_sel_t;

  typedef enum logic [1:0] {
    COL_MID   = 2'd0,
    COL_RIGHT = 2'd1,
    COL_LEFT  = 2'd2
  } col_sel_t;

  // Effective configuration, inner sizes and halos already clamped.
  typedef struct packed {
    logic [DIM_W-1:0]  dx;
    logic [DIM_W-1:0]  dy;
    logic [DIM_W-1:0]  px;
    logic [DIM_W-1:0]  py;
    logic [HALO_W-1:0] hx;
    logic [HALO_W-1:0] hy;
    logic              pr;
    logic              pc;
  } cfg_t;

  // One classified element waiting for its writes to be issued.
  typedef struct packed {
    logic [VALUE_W-1:0]       value;
    logic [2:0][ADDR_W-1:0]   row_base;
    logic [2:0][ADDR_W-1:0]   col;
    logic [NUM_RGN-1:0]       mask;
  } work_t;

  function automatic row_sel_t region_row(region_t r);
    case (r)
      RGN_DOWN, RGN_DOWN_RIGHT, RGN_DOWN_LEFT: return ROW_DOWN;
      RGN_UP, RGN_UP_RIGHT, RGN_UP_LEFT:       return ROW_UP;
      default:                                 return ROW_MID;
    endcase
  endfunction

  function automatic col_sel_t region_col(region_t r);
    case (r)
      RGN_DOWN_RIGHT, RGN_UP_RIGHT, RGN_RIGHT: return COL_RIGHT;
      RGN_DOWN_LEFT, RGN_UP_LEFT, RGN_LEFT:    return COL_LEFT;
      default:                                 return COL_MID;
    endcase
  endfunction

endpackage

// ===== rtl/php_front.sv =====
// Front end: accepts elements, tracks the row/column position and classifies
// each element into its set of destination regions. Depends on php_pkg.
module php_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  php_pkg::cfg_t             cfg,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,
  output logic                      push_valid,
  input  logic                      push_ready,
  output php_pkg::work_t            push_data
);
  import php_pkg::*;

  logic [CNT_W-1:0]       row_r, row_nxt;
  logic [CNT_W-1:0]       col_r, col_nxt;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [VALUE_W-1:0]     s1_value_r;
  logic [2:0][ADDR_W-1:0] s1_row_r, s1_row_nxt;
  logic [2:0][ADDR_W-1:0] s1_col_r, s1_col_nxt;
  logic [NUM_RGN-1:0]     s1_mask_r, s1_mask_nxt;

  logic                   accept;
  logic                   near_top, near_bottom, near_left, near_right;
  logic                   band_down, band_up;
  logic [DIM_W:0]         row_plus_halo, col_plus_halo;
  logic [DIM_W:0]         row_inc, col_inc;
  logic [ADDR_W-1:0]      px_ext;

  // The stage register advances whenever it is empty or its content is queued.
  assign in_tready  = !s1_valid_r || push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = s1_valid_r;

  // Edge tests, all on non-negative sums.
  always_comb begin
    row_plus_halo = (DIM_W+1)'(row_r) + (DIM_W+1)'(cfg.hy);
    col_plus_halo = (DIM_W+1)'(col_r) + (DIM_W+1)'(cfg.hx);
    row_inc       = (DIM_W+1)'(row_r) + (DIM_W+1)'(1);
    col_inc       = (DIM_W+1)'(col_r) + (DIM_W+1)'(1);
    near_top      = (DIM_W+1)'(row_r) < (DIM_W+1)'(cfg.hy);
    near_bottom   = row_plus_halo >= (DIM_W+1)'(cfg.dy);
    near_left     = cfg.pc && ((DIM_W+1)'(col_r) < (DIM_W+1)'(cfg.hx));
    near_right    = cfg.pc && (col_plus_halo >= (DIM_W+1)'(cfg.dx));
    band_down     = cfg.pr && near_top;
    band_up       = cfg.pr && near_bottom;
  end

  // Candidate rows and columns, reduced modulo the address width.
  always_comb begin
    s1_row_nxt[ROW_MID]  = ADDR_W'(row_r) + (cfg.pr ? ADDR_W'(cfg.hy) : '0);
    s1_row_nxt[ROW_DOWN] = ADDR_W'(row_r) + ADDR_W'(cfg.py) - ADDR_W'(cfg.hy);
    s1_row_nxt[ROW_UP]   = ADDR_W'(row_r) + ADDR_W'(cfg.hy) - ADDR_W'(cfg.dy);
    s1_col_nxt[COL_MID]   = ADDR_W'(col_r) + (cfg.pc ? ADDR_W'(cfg.hx) : '0);
    s1_col_nxt[COL_RIGHT] = ADDR_W'(col_r) + ADDR_W'(cfg.px) - ADDR_W'(cfg.hx);
    s1_col_nxt[COL_LEFT]  = ADDR_W'(col_r) + ADDR_W'(cfg.hx) - ADDR_W'(cfg.dx);
  end

  // Region mask, one bit per region code.
  always_comb begin
    s1_mask_nxt                 = '0;
    s1_mask_nxt[RGN_INTERIOR]   = 1'b1;
    s1_mask_nxt[RGN_DOWN]       = band_down;
    s1_mask_nxt[RGN_DOWN_RIGHT] = band_down && near_left;
    s1_mask_nxt[RGN_DOWN_LEFT]  = band_down && near_right;
    s1_mask_nxt[RGN_UP]         = band_up;
    s1_mask_nxt[RGN_UP_RIGHT]   = band_up && near_left;
    s1_mask_nxt[RGN_UP_LEFT]    = band_up && near_right;
    s1_mask_nxt[RGN_RIGHT]      = near_left;
    s1_mask_nxt[RGN_LEFT]       = near_right;
  end

  // Position counters, wrapping at the end of a row and of the matrix.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (col_inc >= (DIM_W+1)'(cfg.dx)) begin
        col_nxt = '0;
        row_nxt = (row_inc >= (DIM_W+1)'(cfg.dy)) ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  assign s1_valid_nxt = accept ? 1'b1 : (push_ready ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_tdata;
      s1_row_r   <= s1_row_nxt;
      s1_col_r   <= s1_col_nxt;
      s1_mask_r  <= s1_mask_nxt;
    end
  end

  // Row bases are formed here so the back end only adds a column.
  assign px_ext = ADDR_W'(cfg.px);

  always_comb begin
    push_data.value              = s1_value_r;
    push_data.row_base[ROW_MID]  = s1_row_r[ROW_MID] * px_ext;
    push_data.row_base[ROW_DOWN] = s1_row_r[ROW_DOWN] * px_ext;
    push_data.row_base[ROW_UP]   = s1_row_r[ROW_UP] * px_ext;
    push_data.col                = s1_col_r;
    push_data.mask               = s1_mask_r;
  end

endmodule

// ===== rtl/php_queue.sv =====
// Short queue of classified elements between the front and back ends.
// Depends on php_pkg for the entry type.
module php_queue #(
  parameter int DEPTH = php_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  php_pkg::work_t push_data,
  output logic           head_valid,
  input  logic           pop,
  output php_pkg::work_t head_data
);
  import php_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t              entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/php_back.sv =====
// Back end: walks the region mask of the queue head, one write per cycle
// unless stalled, holding each in the output register. Depends on php_pkg.
module php_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  php_pkg::work_t head_data,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [87:0]    out_tdata,   // dest_address [23:0], dest_value [87:24]
  output logic [3:0]     out_tuser,   // region [3:0]
  output logic           out_tlast
);
  import php_pkg::*;

  logic [NUM_RGN-1:0]  done_r, done_nxt;
  logic [NUM_RGN-1:0]  remain, pick_bit;
  region_t             pick;
  logic                issue, last;
  row_sel_t            rsel;
  col_sel_t            csel;
  logic [ADDR_W-1:0]   addr;

  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [VALUE_W-1:0]  out_value_r;
  region_t             out_region_r;
  logic                out_last_r;

  // Lowest pending region of the head entry.
  always_comb begin
    remain = head_data.mask & ~done_r;
    pick   = RGN_INTERIOR;
    for (int k = NUM_RGN - 1; k >= 0; k--) begin
      if (remain[k]) begin
        pick = region_t'(4'(k));
      end
    end
    pick_bit = NUM_RGN'(1) << pick;
    last     = (remain & ~pick_bit) == '0;
  end

  // Address of the chosen region.
  always_comb begin
    rsel = region_row(pick);
    csel = region_col(pick);
    addr = head_data.row_base[rsel] + head_data.col[csel];
  end

  assign issue = head_valid && (!out_valid_r || out_tready);
  assign pop   = issue && last;

  always_comb begin
    done_nxt = done_r;
    if (issue) begin
      done_nxt = last ? '0 : (done_r | pick_bit);
    end
    out_valid_nxt = issue ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_addr_r   <= addr;
      out_value_r  <= head_data.value;
      out_region_r <= pick;
      out_last_r   <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_value_r, out_addr_r};
  assign out_tuser  = out_region_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // Regions already issued always belong to the current head entry.
  a_done_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (done_r & ~head_data.mask) == '0)
    else $error("issued regions outside head mask");

  // Progress is cleared whenever no entry is pending.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> done_r == '0)
    else $error("stale region progress with empty queue");

  // The interior write always opens an element.
  a_interior_first: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && pick == RGN_INTERIOR) |-> done_r == '0)
    else $error("interior write issued mid-element");

  // A write that is not the last leaves the entry in the queue.
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && !last) |=> head_valid && done_r != '0)
    else $error("entry lost before its last write");
`endif

endmodule

// ===== rtl/periodic_halo_padding_top.sv =====
// Periodic halo padding: each input element yields 1 to 9 write transactions.
// An element passes the front-end stage register, the queue and the output
// register. One write per cycle while out_tready does not stall the output,
// set by the back end's single issue port; an element's writes issue in turn.
// Reset (synchronous, active low): counters zero, queue empty, registers at
// sizes 1, halos 0, wrap flags 0. Depends on php_pkg and the php_* modules.
module periodic_halo_padding_top #(
  parameter int QDEPTH = php_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // Input elements.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // element_value [63:0]
  // Write transactions.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // dest_address [23:0], dest_value [87:24]
  output logic [3:0]  out_tuser,  // region [3:0]
  output logic        out_tlast   // last_write
);
  import php_pkg::*;

  logic [DIM_W-1:0]  inner_width_r, inner_height_r;
  logic [DIM_W-1:0]  padded_width_r, padded_height_r;
  logic [HALO_W-1:0] halo_cols_r, halo_rows_r;
  logic              wrap_rows_r, wrap_cols_r;
  cfg_t              cfg;

  logic              push_valid, push_ready;
  work_t             push_data;
  logic              head_valid, pop;
  work_t             head_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_width_r   <= DIM_W'(1);
      inner_height_r  <= DIM_W'(1);
      padded_width_r  <= DIM_W'(1);
      padded_height_r <= DIM_W'(1);
      halo_cols_r     <= '0;
      halo_rows_r     <= '0;
      wrap_rows_r     <= 1'b0;
      wrap_cols_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_INNER_WIDTH:   inner_width_r   <= cfg_data;
        CFG_INNER_HEIGHT:  inner_height_r  <= cfg_data;
        CFG_PADDED_WIDTH:  padded_width_r  <= cfg_data;
        CFG_PADDED_HEIGHT: padded_height_r <= cfg_data;
        CFG_HALO_COLS:     halo_cols_r     <= cfg_data[HALO_W-1:0];
        CFG_HALO_ROWS:     halo_rows_r     <= cfg_data[HALO_W-1:0];
        CFG_WRAP_ROWS:     wrap_rows_r     <= cfg_data[0];
        CFG_WRAP_COLS:     wrap_cols_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: a zero inner size acts as one, large values saturate.
  always_comb begin
    cfg.dx = (inner_width_r == '0) ? DIM_W'(1) :
             (inner_width_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : inner_width_r;
    cfg.dy = (inner_height_r == '0) ? DIM_W'(1) :
             (inner_height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : inner_height_r;
    cfg.px = padded_width_r;
    cfg.py = padded_height_r;
    cfg.hx = (9'(halo_cols_r) > 9'(MAX_HALO)) ? HALO_W'(MAX_HALO) : halo_cols_r;
    cfg.hy = (9'(halo_rows_r) > 9'(MAX_HALO)) ? HALO_W'(MAX_HALO) : halo_rows_r;
    cfg.pr = wrap_rows_r;
    cfg.pc = wrap_cols_r;
  end

  php_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  php_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  php_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sim/periodic_halo_padding_top_tb.sv =====
// Self-checking testbench for periodic_halo_padding_top: streams matrix elements,
// predicts every padded-matrix write in its own model and checks each transaction.
// Depends on php_pkg and the RTL under rtl; reads no files.
`timescale 1ns / 100ps

module periodic_halo_padding_top_tb;
  import php_pkg::*;

  // One expected write into the padded matrix.
  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    region_t            region;
    logic               last;
  } pad_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_t    cfg_index = CFG_INNER_WIDTH;
  logic [12:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // element_value [63:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;       // dest_address [23:0], dest_value [87:24]
  logic [3:0]  out_tuser;       // region [3:0]
  logic        out_tlast;       // last_write

  // Shadow of the configuration registers and of the position counters.
  logic [DIM_W-1:0]  src_cols = 13'd1;
  logic [DIM_W-1:0]  src_rows = 13'd1;
  logic [DIM_W-1:0]  pad_pitch = 13'd1;
  logic [DIM_W-1:0]  pad_rows = 13'd1;
  logic [HALO_W-1:0] halo_x = '0;
  logic [HALO_W-1:0] halo_y = '0;
  logic              periodic_rows = 1'b0;
  logic              periodic_cols = 1'b0;
  logic [CNT_W-1:0]  row_pos = '0;
  logic [CNT_W-1:0]  col_pos = '0;

  logic [63:0] source_elems[$];
  pad_write_t  due_writes[$];
  pad_write_t  head;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  bit          steady = 1'b0;
  int          mism_count = 0;

  periodic_halo_padding_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; none at all in steady stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queues one write; the address is a signed flat index wrapped to 24 bits.
  function automatic void push_write(longint row, longint col, longint pitch,
                                     logic [63:0] value, region_t rgn);
    pad_write_t w;
    longint flat;
    flat = row * pitch + col;
    w.addr = flat[ADDR_W-1:0];
    w.value = value;
    w.region = rgn;
    w.last = 1'b0;
    due_writes.push_back(w);
  endfunction

  // Works out every write caused by one element and advances the position.
  function automatic void expand_element(logic [63:0] value);
    longint dx, dy, px, py, hx, hy, i, j;
    longint mid_row, mid_col, down_row, up_row, right_col, left_col;
    bit near_top, near_bottom, near_left, near_right;
    // Inner sizes are clamped to 1..MAX_DIM, halos to MAX_HALO.
    dx = longint'(src_cols);
    if (dx == 0) dx = 1;
    else if (dx > MAX_DIM) dx = MAX_DIM;
    dy = longint'(src_rows);
    if (dy == 0) dy = 1;
    else if (dy > MAX_DIM) dy = MAX_DIM;
    px = longint'(pad_pitch);
    py = longint'(pad_rows);
    hx = longint'(halo_x);
    if (hx > MAX_HALO) hx = MAX_HALO;
    hy = longint'(halo_y);
    if (hy > MAX_HALO) hy = MAX_HALO;
    i = longint'(row_pos);
    j = longint'(col_pos);

    mid_row = i + (periodic_rows ? hy : 0);
    mid_col = j + (periodic_cols ? hx : 0);
    down_row = i + py - hy;
    up_row = i - (dy - hy);
    right_col = j + px - hx;
    left_col = j - (dx - hx);
    near_top = i < hy;
    near_bottom = i >= dy - hy;
    near_left = periodic_cols && (j < hx);
    near_right = periodic_cols && (j >= dx - hx);

    push_write(mid_row, mid_col, px, value, RGN_INTERIOR);
    if (periodic_rows && near_top) begin
      push_write(down_row, mid_col, px, value, RGN_DOWN);
      if (near_left) push_write(down_row, right_col, px, value, RGN_DOWN_RIGHT);
      if (near_right) push_write(down_row, left_col, px, value, RGN_DOWN_LEFT);
    end
    if (periodic_rows && near_bottom) begin
      push_write(up_row, mid_col, px, value, RGN_UP);
      if (near_left) push_write(up_row, right_col, px, value, RGN_UP_RIGHT);
      if (near_right) push_write(up_row, left_col, px, value, RGN_UP_LEFT);
    end
    if (near_left) push_write(mid_row, right_col, px, value, RGN_RIGHT);
    if (near_right) push_write(mid_row, left_col, px, value, RGN_LEFT);
    due_writes[due_writes.size() - 1].last = 1'b1;

    // A counter at or past its last index wraps when the column wraps.
    if (j >= dx - 1) begin
      col_pos = '0;
      if (i >= dy - 1) row_pos = '0;
      else row_pos = CNT_W'(i + 1);
    end else begin
      col_pos = CNT_W'(j + 1);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mism_count++;
    end
  endfunction

  // Element driver: presents queued elements, predicting each one on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) expand_element(in_tdata);
      if (in_tvalid && !in_tready) begin
        // Hold the current transaction until it is taken.
      end else if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (source_elems.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= source_elems.pop_front();
        send_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Write monitor: checks each accepted transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_writes.size() == 0) begin
          $error("unexpected write: address 0x%0h, region %0d", out_tdata[23:0], out_tuser);
          mism_count++;
        end else begin
          head = due_writes.pop_front();
          check_field("dest_address", 64'(head.addr), 64'(out_tdata[23:0]));
          check_field("dest_value", head.value, out_tdata[87:24]);
          check_field("region", 64'(head.region), 64'(out_tuser));
          check_field("last_write", 64'(head.last), 64'(out_tlast));
        end
      end
      if (take_gap != 0) begin
        out_tready <= 1'b0;
        take_gap <= take_gap - 1;
      end else begin
        out_tready <= 1'b1;
        take_gap <= pick_gap();
      end
    end
  end

  // One register write; the shadow copy keeps only the bits the register holds.
  task automatic set_reg(input cfg_reg_t idx, input logic [12:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INNER_WIDTH:   src_cols = data;
      CFG_INNER_HEIGHT:  src_rows = data;
      CFG_PADDED_WIDTH:  pad_pitch = data;
      CFG_PADDED_HEIGHT: pad_rows = data;
      CFG_HALO_COLS:     halo_x = data[7:0];
      CFG_HALO_ROWS:     halo_y = data[7:0];
      CFG_WRAP_ROWS:     periodic_rows = data[0];
      default:           periodic_cols = data[0];
    endcase
  endtask

  // Writes all eight registers; unused upper data bits carry random junk.
  task automatic configure(input int unsigned iw, ih, pw, ph, hc, hr, input bit wr, wc);
    logic [4:0]  junk5;
    logic [11:0] junk12;
    set_reg(CFG_INNER_WIDTH, iw[12:0]);
    set_reg(CFG_INNER_HEIGHT, ih[12:0]);
    set_reg(CFG_PADDED_WIDTH, pw[12:0]);
    set_reg(CFG_PADDED_HEIGHT, ph[12:0]);
    junk5 = $urandom_range(0, 31);
    set_reg(CFG_HALO_COLS, {junk5, hc[7:0]});
    junk5 = $urandom_range(0, 31);
    set_reg(CFG_HALO_ROWS, {junk5, hr[7:0]});
    junk12 = $urandom;
    set_reg(CFG_WRAP_ROWS, {junk12, wr});
    junk12 = $urandom;
    set_reg(CFG_WRAP_COLS, {junk12, wc});
  endtask

  // Waits until every element is taken and every predicted write has arrived.
  // Sampling on the falling edge sees the driver's and monitor's updates settled.
  task automatic drain();
    @(negedge clk);
    while (source_elems.size() != 0 || in_tvalid || due_writes.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned iw, ih, pw, ph, hc, hr, n, sent, cells;
    bit wr, wc;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a one-element matrix, so every element lands at address zero.
    source_elems.push_back('0);
    source_elems.push_back('1);
    drain();

    // 3x3 with a one-wide halo on both periodic axes reaches every region.
    configure(3, 3, 5, 5, 1, 1, 1'b1, 1'b1);
    for (int k = 0; k < 9; k++)
      source_elems.push_back(k[0] ? {32{2'b10}} : {32{2'b01}});
    drain();

    // Zero width acts as one, halos cover the whole matrix: all nine writes per
    // element, and down-band rows go negative so addresses wrap.
    configure(0, 2, 8191, 0, 255, 255, 1'b1, 1'b1);
    repeat (4) source_elems.push_back({$urandom, $urandom});
    drain();

    // Oversized width clamps to the maximum; only the row axis is periodic.
    configure(8191, 0, 4096, 4096, 3, 2, 1'b1, 1'b0);
    repeat (3) source_elems.push_back({$urandom, $urandom});
    drain();

    // Shrinking the width mid-row leaves the column counter past its last index.
    configure(2, 3, 6, 7, 2, 2, 1'b1, 1'b1);
    repeat (3) source_elems.push_back({$urandom, $urandom});
    drain();

    // Random settings, mostly small well-formed matrices streamed whole.
    sent = 0;
    for (int phase = 0; sent < 75; phase++) begin
      steady = ($urandom_range(0, 3) == 0);
      iw = $urandom_range(1, 6);
      ih = $urandom_range(1, 6);
      hc = $urandom_range(0, 3);
      hr = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) iw = $urandom_range(0, 1) ? 0 : $urandom_range(4096, 8191);
      if ($urandom_range(0, 7) == 0) ih = $urandom_range(0, 1) ? 0 : $urandom_range(4096, 8191);
      if ($urandom_range(0, 7) == 0) hc = $urandom_range(0, 255);
      if ($urandom_range(0, 7) == 0) hr = $urandom_range(0, 255);
      pw = iw + 2 * hc;
      ph = ih + 2 * hr;
      if ($urandom_range(0, 7) == 0) pw = $urandom_range(0, 8191);
      if ($urandom_range(0, 7) == 0) ph = $urandom_range(0, 8191);
      wr = $urandom_range(0, 1);
      wc = $urandom_range(0, 1);
      configure(iw, ih, pw, ph, hc, hr, wr, wc);

      cells = ((iw == 0) ? 1 : iw) * ((ih == 0) ? 1 : ih);
      n = cells * $urandom_range(1, 2);
      if (n > 30) n = $urandom_range(12, 30);
      for (int k = 0; k < n; k++) begin
        // Once, hold the stream back until all writes so far are in.
        if (phase == 0 && k == n / 2) drain();
        source_elems.push_back({$urandom, $urandom});
      end
      sent += n;
      drain();
    end

    steady = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (mism_count == 0) $display("periodic_halo_padding_top: match");
    else $display("periodic_halo_padding_top: mismatch");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("periodic_halo_padding_top: mismatch");
    $finish;
  end

endmodule

// ===== periodic_halo_padding_top.f =====
rtl/php_pkg.sv
rtl/php_front.sv
rtl/php_queue.sv
rtl/php_back.sv
rtl/periodic_halo_padding_top.sv
sim/periodic_halo_padding_top_tb.sv
